// ===== sv/aes128_block_cipher_macros.svh =====
// Assertion helpers for the AES-128 block cipher.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

`define AES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/aes_pkg.sv =====
package aes_pkg;

    localparam int NumRounds = 10;

    typedef enum logic [1:0] {
        REG_KEY_HIGH     = 2'd0,
        REG_KEY_LOW      = 2'd1,
        REG_DECRYPT_MODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic        decrypt;
        logic [127:0] st;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] u, v;
        logic [31:0] p;
        u = xtime(xtime(c[31:24] ^ c[15:8]));
        v = xtime(xtime(c[23:16] ^ c[7:0]));
        p = {c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v};
        return mix_col(p);
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            r[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32])
                                    : mix_col(s[127-32*c -: 32]);
        end
        return r;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] b;
        for (int c = 0; c < 4; c++) begin
            for (int rr = 0; rr < 4; rr++) begin
                if (inv) begin
                    b = s[127-8*(4*c+rr) -: 8];
                    r[127-8*(4*((c+rr)%4)+rr) -: 8] = INV_SBOX[b];
                end else begin
                    b = s[127-8*(4*((c+rr)%4)+rr) -: 8];
                    r[127-8*(4*c+rr) -: 8] = SBOX[b];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== sv/aes_key_sched.sv =====
module aes_key_sched (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  logic [127:0] key,
    output logic [127:0] rk [aes_pkg::NumRounds+1],
    output logic         busy
);
    logic [127:0] rk_reg [aes_pkg::NumRounds+1];
    logic [127:0] rk_next [aes_pkg::NumRounds+1];
    logic [3:0]   cnt_reg, cnt_next;

    always_comb begin
        rk_next = rk_reg;
        cnt_next = cnt_reg;
        if (load) begin
            rk_next[0] = key;
            cnt_next = 4'd0;
        end else if (cnt_reg < 4'(aes_pkg::NumRounds)) begin
            rk_next[cnt_reg + 4'd1] = aes_pkg::next_rk(rk_reg[cnt_reg], aes_pkg::RCON[cnt_reg]);
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
            rk_reg[0] <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rk_reg[0] <= rk_next[0];
        end
        for (int i = 1; i <= aes_pkg::NumRounds; i++) rk_reg[i] <= rk_next[i];
    end

    assign rk = rk_reg;
    assign busy = load || (cnt_reg < 4'(aes_pkg::NumRounds));
endmodule

// ===== sv/aes_round_cell.sv =====
module aes_round_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            last,
    input  logic [127:0]    rkey,
    input  aes_pkg::stage_t din,
    output aes_pkg::stage_t dout
);
    aes_pkg::stage_t dout_reg, dout_next;
    logic [127:0] ss, mixed, k;

    always_comb begin
        ss = aes_pkg::sub_shift(din.st, din.decrypt);
        mixed = last ? ss : aes_pkg::mix_all(ss, din.decrypt);
        k = (din.decrypt && !last) ? aes_pkg::mix_all(rkey, 1'b1) : rkey;
        dout_next.valid = din.valid;
        dout_next.decrypt = din.decrypt;
        dout_next.st = mixed ^ k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.valid <= 1'b0;
        end else if (advance) begin
            dout_reg.valid <= dout_next.valid;
        end
        if (advance) begin
            dout_reg.decrypt <= dout_next.decrypt;
            dout_reg.st <= dout_next.st;
        end
    end

    assign dout = dout_reg;
endmodule

// ===== sv/aes128_block_cipher.sv =====
// AES-128 ECB engine: ten round cells in a chain, one block per cycle
// sustained; each block is registered in the initial key-add stage and then
// in each of the ten round cells. The whole chain stalls when the output is
// held. Writing a key register restarts the round-key sweep, one round key
// per cycle; no block is accepted during it. decrypt_mode selects the
// equivalent inverse cipher per block.
`include "aes128_block_cipher_macros.svh"
module aes128_block_cipher (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  aes_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output aes_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    localparam int N = aes_pkg::NumRounds;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         decrypt_reg;
    logic [127:0] rk [N+1];
    logic         ks_busy, key_wr, advance;
    aes_pkg::stage_t st0_reg;
    aes_pkg::stage_t chain [N+1];

    assign cfg_ready = 1'b1;
    assign key_wr = cfg_valid && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                                  cfg_index == aes_pkg::REG_KEY_LOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            decrypt_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH:     key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:      key_low_reg <= cfg_data;
                aes_pkg::REG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_key_sched u_ks (
        .aclk(aclk), .aresetn(aresetn), .load(key_wr),
        .key({cfg_index == aes_pkg::REG_KEY_HIGH ? cfg_data : key_high_reg,
              cfg_index == aes_pkg::REG_KEY_LOW ? cfg_data : key_low_reg}),
        .rk(rk), .busy(ks_busy)
    );

    assign advance = !chain[N].valid || m_ready;
    assign s_ready = advance && !ks_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (advance) begin
            st0_reg.valid <= s_valid && s_ready;
        end
        if (advance) begin
            st0_reg.decrypt <= decrypt_reg;
            st0_reg.st <= {s_data.block_high, s_data.block_low}
                          ^ (decrypt_reg ? rk[N] : rk[0]);
        end
    end

    assign chain[0] = st0_reg;

    for (genvar g = 1; g <= N; g++) begin : g_cell
        aes_round_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .advance(advance),
            .last(g == N),
            .rkey(chain[g-1].decrypt ? rk[N-g] : rk[g]),
            .din(chain[g-1]), .dout(chain[g])
        );
    end

    assign m_valid = chain[N].valid;
    assign m_data.out_high = chain[N].st[127:64];
    assign m_data.out_low = chain[N].st[63:0];

    `AES_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `AES_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, ks_busy, !s_ready)
    `AES_ASSERT_NEXT(a_flow, aclk, aresetn, s_valid && s_ready, st0_reg.valid)
endmodule
